>>> design/dsi_pkg.sv
// Shared types and constants of the daily schedule interpolator.
package dsi_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int ACT_W    = 2;
  localparam int STAT_W   = 2;
  localparam int TIME_W   = 17;
  localparam int LEVEL_W  = 16;
  localparam int MS_W     = 27;
  localparam int ENTRY_W  = TIME_W + LEVEL_W;

  localparam int DAY_SECONDS = 86400;
  localparam int MS_PER_S    = 1000;
  localparam int DAY_MS      = DAY_SECONDS * MS_PER_S;

  localparam int DIV_STEPS = LEVEL_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int PROD_W    = MS_W + LEVEL_W;
  localparam int DSH_W     = MS_W + DIV_STEPS - 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_SET   = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

endpackage

>>> design/dsi_ram.sv
// Generic memory with one write port and one registered read port.
module dsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/daily_schedule_interpolator.sv
// Top level: point table in memory, scan sequencer and serial interpolation divider.
// Clear, no-op and rejected transactions go straight from the idle state to the output state.
// A set point reads and compares the stored points in turn, then overwrites a match or appends.
// A query scans every stored point, then runs the 16-step divider, or skips it on a single bound.
// One transaction is in work at a time; the next is accepted once the state is back in idle after its result registers.
// Reset clears the point count and the output valid; the point memory is not cleared.
module daily_schedule_interpolator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [dsi_pkg::ACT_W-1:0]   action_i,
  input  logic [dsi_pkg::TIME_W-1:0]  point_seconds_i,
  input  logic [dsi_pkg::LEVEL_W-1:0] point_level_i,
  input  logic [dsi_pkg::MS_W-1:0]    query_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [dsi_pkg::LEVEL_W-1:0] level_o,
  output logic [dsi_pkg::STAT_W-1:0]  status_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CMP, S_INS, S_PREP, S_DT, S_MUL, S_DIV, S_FIN, S_OUT
  } state_e;

  state_e                          state_q;
  dsi_pkg::action_e                act_q;
  logic [dsi_pkg::TIME_W-1:0]      secs_q;
  logic [dsi_pkg::LEVEL_W-1:0]     lvl_q;
  logic [dsi_pkg::MS_W-1:0]        qms_q;
  logic [dsi_pkg::CNT_W-1:0]       cnt_q;
  logic [dsi_pkg::CNT_W-1:0]       idx_q;

  logic [dsi_pkg::TIME_W-1:0]      max_t_q, min_t_q, s_t_q, e_t_q;
  logic [dsi_pkg::LEVEL_W-1:0]     max_v_q, min_v_q, s_v_q, e_v_q;
  logic                            s_found_q, e_found_q;

  logic [dsi_pkg::LEVEL_W-1:0]     v0_q, v1_q;
  logic signed [28:0]              s_ms_q;
  logic [dsi_pkg::TIME_W-1:0]      den_s_q;
  logic [dsi_pkg::MS_W-1:0]        dt_q, den_q;
  logic [dsi_pkg::LEVEL_W-1:0]     dvm_q, qm_q;
  logic                            neg_q;
  logic [dsi_pkg::PROD_W-1:0]      rem_q;
  logic [dsi_pkg::DSH_W-1:0]       dsh_q;
  logic [dsi_pkg::STEP_W-1:0]      step_q;

  logic [dsi_pkg::LEVEL_W-1:0]     res_level_q;
  dsi_pkg::status_e                res_status_q;
  logic                            out_valid_q;
  logic [dsi_pkg::LEVEL_W-1:0]     level_q;
  logic [dsi_pkg::STAT_W-1:0]      status_q;

  logic                            ram_we, ram_re;
  logic [dsi_pkg::IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [dsi_pkg::ENTRY_W-1:0]     ram_wdata, ram_rdata;

  logic [dsi_pkg::TIME_W-1:0]      rd_time;
  logic [dsi_pkg::LEVEL_W-1:0]     rd_val;
  logic [dsi_pkg::MS_W-1:0]        rd_ms;
  logic                            last_entry, in_acc, table_full;

  logic [dsi_pkg::TIME_W-1:0]      s_raw, e_raw;
  logic signed [18:0]              s_adj, e_adj;
  logic signed [28:0]              dt_full;
  logic signed [16:0]              dv;
  logic                            rem_ge;
  logic signed [18:0]              q_mag, q_fl, r_sum;

  dsi_ram #(
    .WIDTH(dsi_pkg::ENTRY_W),
    .DEPTH(dsi_pkg::MAX_POINTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign table_full = (cnt_q >= dsi_pkg::CNT_W'(dsi_pkg::MAX_POINTS));
  assign last_entry = ((idx_q + dsi_pkg::CNT_W'(1)) == cnt_q);

  assign rd_time = ram_rdata[dsi_pkg::ENTRY_W-1:dsi_pkg::LEVEL_W];
  assign rd_val  = ram_rdata[dsi_pkg::LEVEL_W-1:0];
  assign rd_ms   = dsi_pkg::MS_W'(rd_time) * dsi_pkg::MS_W'(dsi_pkg::MS_PER_S);

  always_comb begin
    ram_re    = (state_q == S_RD);
    ram_raddr = idx_q[dsi_pkg::IDX_W-1:0];
    ram_wdata = {secs_q, lvl_q};
    ram_we    = 1'b0;
    ram_waddr = idx_q[dsi_pkg::IDX_W-1:0];
    case (state_q)
      S_CMP: begin
        ram_we = (act_q == dsi_pkg::ACT_SET) && (rd_time == secs_q);
      end
      S_INS: begin
        ram_we    = !table_full;
        ram_waddr = cnt_q[dsi_pkg::IDX_W-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    s_raw   = s_found_q ? s_t_q : max_t_q;
    e_raw   = e_found_q ? e_t_q : min_t_q;
    s_adj   = $signed({2'b00, s_raw}) -
              (s_found_q ? 19'sd0 : $signed(19'(dsi_pkg::DAY_SECONDS)));
    e_adj   = $signed({2'b00, e_raw}) +
              (e_found_q ? 19'sd0 : $signed(19'(dsi_pkg::DAY_SECONDS)));
    dt_full = $signed({2'b00, qms_q}) - s_ms_q;
    dv      = $signed({1'b0, v1_q}) - $signed({1'b0, v0_q});
    rem_ge  = (rem_q >= dsi_pkg::PROD_W'(dsh_q));
    q_mag   = $signed({3'b000, qm_q});
    q_fl    = neg_q ? (-q_mag - ((rem_q != '0) ? 19'sd1 : 19'sd0)) : q_mag;
    r_sum   = $signed({3'b000, v0_q}) + q_fl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            act_q       <= dsi_pkg::action_e'(action_i);
            secs_q      <= point_seconds_i;
            lvl_q       <= point_level_i;
            qms_q       <= query_ms_i;
            idx_q       <= '0;
            s_found_q   <= 1'b0;
            e_found_q   <= 1'b0;
            res_level_q <= '0;
            case (dsi_pkg::action_e'(action_i))
              dsi_pkg::ACT_CLEAR: begin
                cnt_q        <= '0;
                res_status_q <= dsi_pkg::STAT_OK;
                state_q      <= S_OUT;
              end
              dsi_pkg::ACT_SET: begin
                if (point_seconds_i >= dsi_pkg::TIME_W'(dsi_pkg::DAY_SECONDS)) begin
                  res_status_q <= dsi_pkg::STAT_RANGE;
                  state_q      <= S_OUT;
                end else if (cnt_q == '0) begin
                  res_status_q <= dsi_pkg::STAT_OK;
                  state_q      <= S_INS;
                end else begin
                  res_status_q <= dsi_pkg::STAT_OK;
                  state_q      <= S_RD;
                end
              end
              dsi_pkg::ACT_QUERY: begin
                if (query_ms_i >= dsi_pkg::MS_W'(dsi_pkg::DAY_MS)) begin
                  res_status_q <= dsi_pkg::STAT_RANGE;
                  state_q      <= S_OUT;
                end else if (cnt_q == '0) begin
                  res_status_q <= dsi_pkg::STAT_EMPTY;
                  state_q      <= S_OUT;
                end else begin
                  res_status_q <= dsi_pkg::STAT_OK;
                  state_q      <= S_RD;
                end
              end
              default: begin
                res_status_q <= dsi_pkg::STAT_OK;
                state_q      <= S_OUT;
              end
            endcase
          end
        end
        S_RD: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          idx_q <= idx_q + dsi_pkg::CNT_W'(1);
          if (act_q == dsi_pkg::ACT_SET) begin
            if (rd_time == secs_q) begin
              state_q <= S_OUT;
            end else begin
              state_q <= last_entry ? S_INS : S_RD;
            end
          end else begin
            if (idx_q == '0 || rd_time > max_t_q) begin
              max_t_q <= rd_time;
              max_v_q <= rd_val;
            end
            if (idx_q == '0 || rd_time < min_t_q) begin
              min_t_q <= rd_time;
              min_v_q <= rd_val;
            end
            if (rd_ms <= qms_q && (!s_found_q || rd_time > s_t_q)) begin
              s_found_q <= 1'b1;
              s_t_q     <= rd_time;
              s_v_q     <= rd_val;
            end
            if (rd_ms >= qms_q && (!e_found_q || rd_time < e_t_q)) begin
              e_found_q <= 1'b1;
              e_t_q     <= rd_time;
              e_v_q     <= rd_val;
            end
            state_q <= last_entry ? S_PREP : S_RD;
          end
        end
        S_INS: begin
          if (table_full) begin
            res_status_q <= dsi_pkg::STAT_FULL;
          end else begin
            cnt_q <= cnt_q + dsi_pkg::CNT_W'(1);
          end
          state_q <= S_OUT;
        end
        S_PREP: begin
          v0_q    <= s_found_q ? s_v_q : max_v_q;
          v1_q    <= e_found_q ? e_v_q : min_v_q;
          s_ms_q  <= 29'(s_adj) * $signed(29'(dsi_pkg::MS_PER_S));
          den_s_q <= dsi_pkg::TIME_W'(e_adj - s_adj);
          if (s_raw == e_raw) begin
            res_level_q <= s_found_q ? s_v_q : max_v_q;
            state_q     <= S_OUT;
          end else begin
            state_q <= S_DT;
          end
        end
        S_DT: begin
          dt_q    <= dt_full[dsi_pkg::MS_W-1:0];
          den_q   <= dsi_pkg::MS_W'(den_s_q) * dsi_pkg::MS_W'(dsi_pkg::MS_PER_S);
          neg_q   <= dv[16];
          dvm_q   <= dv[16] ? dsi_pkg::LEVEL_W'(-dv) : dv[dsi_pkg::LEVEL_W-1:0];
          state_q <= S_MUL;
        end
        S_MUL: begin
          rem_q   <= dsi_pkg::PROD_W'(dt_q) * dsi_pkg::PROD_W'(dvm_q);
          dsh_q   <= {den_q, (dsi_pkg::DIV_STEPS - 1)'(0)};
          qm_q    <= '0;
          step_q  <= dsi_pkg::STEP_W'(dsi_pkg::DIV_STEPS - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (rem_ge) begin
            rem_q <= rem_q - dsi_pkg::PROD_W'(dsh_q);
          end
          qm_q   <= {qm_q[dsi_pkg::LEVEL_W-2:0], rem_ge};
          dsh_q  <= dsh_q >> 1;
          step_q <= step_q - dsi_pkg::STEP_W'(1);
          if (step_q == '0) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (r_sum < 0) begin
            res_level_q <= '0;
          end else if (r_sum > $signed(19'(65535))) begin
            res_level_q <= '1;
          end else begin
            res_level_q <= r_sum[dsi_pkg::LEVEL_W-1:0];
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            level_q     <= res_level_q;
            status_q    <= res_status_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= dsi_pkg::CNT_W'(dsi_pkg::MAX_POINTS))
    else $error("point count exceeds the table size");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (cnt_q == $past(cnt_q) || cnt_q == '0 ||
              cnt_q == $past(cnt_q) + dsi_pkg::CNT_W'(1)))
    else $error("point count changed by more than one");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CMP || state_q == S_INS))
    else $error("table written outside the set sequence");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |-> rem_q < dsi_pkg::PROD_W'(den_q))
    else $error("division remainder not below the divisor");

  a_level_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && level_o != '0) |-> status_o == dsi_pkg::STAT_OK)
    else $error("non-zero level returned with an error status");
`endif

endmodule
